FILE: hw/rtl/multi_joint_slew_limiter_macros.svh
// Assertion helpers for the slew limiter.
`ifndef MULTI_JOINT_SLEW_LIMITER_MACROS_SVH
`define MULTI_JOINT_SLEW_LIMITER_MACROS_SVH

// Checked outside reset.
`define MJSL_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every edge, reset included.
`define MJSL_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: hw/rtl/mjsl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mjsl_pkg;

   localparam int ANGLE_BITS    = 16;
   localparam int NUM_JOINTS    = 3;
   localparam int SPEED_BITS    = 15;
   localparam int TIME_BITS     = 32;
   localparam int FRAME_BITS    = 2;
   localparam int OFF_BITS      = ANGLE_BITS + 3;
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;
   localparam int REG_IDX_BITS  = 3;

   typedef logic signed [ANGLE_BITS-1:0] angle_type;
   typedef logic [SPEED_BITS-1:0]        speed_type;
   typedef logic [TIME_BITS-1:0]         time_type;

   typedef enum logic [1:0] {
      OP_SET      = 2'd0,
      OP_TICK     = 2'd1,
      OP_SNAPSHOT = 2'd2,
      OP_FREEZE   = 2'd3
   } op_type;

   typedef enum logic [REG_IDX_BITS-1:0] {
      REG_SPEED_A = 3'd0,
      REG_SPEED_B = 3'd1,
      REG_SPEED_C = 3'd2,
      REG_HOLD    = 3'd3,
      REG_TOL     = 3'd4,
      REG_TIMEOUT = 3'd5
   } reg_idx_type;

   localparam logic      HOLD_RESET    = 1'b1;
   localparam speed_type TOL_RESET     = 15'd205;
   localparam time_type  TIMEOUT_RESET = 32'd2000;

   typedef struct packed {
      op_type    operation;
      angle_type goal_a;
      angle_type goal_b;
      angle_type goal_c;
      angle_type sensed_a;
      angle_type sensed_b;
      angle_type sensed_c;
      time_type  now_ms;
   } req_type;

   typedef struct packed {
      logic [FRAME_BITS-1:0] frame_index;
      angle_type             drive_a;
      angle_type             drive_b;
      angle_type             drive_c;
      logic                  frame_written;
      logic                  last_frame;
      logic                  reached_event;
      logic                  alive;
   } rsp_type;

   typedef struct packed {
      logic   accept;
      op_type op;
      logic   run;
      logic   advance;
   } lane_ctl_type;

   typedef struct packed {
      logic done;
      logic off_tol;
   } lane_stat_type;

   typedef struct packed {
      logic reached;
      logic alive;
   } merge_type;

endpackage

`default_nettype wire

FILE: hw/rtl/multi_joint_slew_limiter.sv
`timescale 1ns / 1ps
`default_nettype none

// Three-joint slew limiter. Set, snapshot and freeze items do not occupy the
// block and give no result. An update tick gives NUM_FRAMES frame results,
// one per cycle while the output is not stalled: a frame counter walks the
// three joint lanes through the frames, one frame into the output register
// each cycle unless the output stalls. When nothing is pending and hold is
// off, a tick gives a single status-only result. The next item is taken in
// the cycle that issues the last frame of the current tick; a stalled output
// holds the frame counter and so delays that cycle. Registers at byte
// addresses 0x00/0x04/0x08: per-joint step limits (Q3.12, 0 jumps to target),
// 0x0C hold enable, 0x10 arrival tolerance, 0x14 timeout in ms; write only
// while no item is in flight.

module multi_joint_slew_limiter
   import mjsl_pkg::*;
#(
   parameter int NUM_FRAMES = 4
) (
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     req_valid,
   output logic                     req_stall,
   input  req_type                  req_data,

   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rsp_type                  rsp_data,

   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

`include "multi_joint_slew_limiter_macros.svh"

   // configuration
   speed_type   speed_ff [NUM_JOINTS];
   logic        hold_ff;
   speed_type   tol_ff;
   time_type    timeout_ff;
   logic        csr_wr;
   reg_idx_type reg_sel;

   assign pready  = 1'b1;
   assign csr_wr  = psel & penable & pwrite;
   assign reg_sel = reg_idx_type'(paddr[CSR_ADDR_BITS-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < NUM_JOINTS; j++) begin
            speed_ff[j] <= '0;
         end
         hold_ff    <= HOLD_RESET;
         tol_ff     <= TOL_RESET;
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_wr) begin
         unique case (reg_sel)
            REG_SPEED_A: speed_ff[0] <= pwdata[SPEED_BITS-1:0];
            REG_SPEED_B: speed_ff[1] <= pwdata[SPEED_BITS-1:0];
            REG_SPEED_C: speed_ff[2] <= pwdata[SPEED_BITS-1:0];
            REG_HOLD:    hold_ff     <= pwdata[0];
            REG_TOL:     tol_ff      <= pwdata[SPEED_BITS-1:0];
            REG_TIMEOUT: timeout_ff  <= pwdata[TIME_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_SPEED_A: prdata = CSR_DATA_BITS'(speed_ff[0]);
         REG_SPEED_B: prdata = CSR_DATA_BITS'(speed_ff[1]);
         REG_SPEED_C: prdata = CSR_DATA_BITS'(speed_ff[2]);
         REG_HOLD:    prdata = CSR_DATA_BITS'(hold_ff);
         REG_TOL:     prdata = CSR_DATA_BITS'(tol_ff);
         REG_TIMEOUT: prdata = CSR_DATA_BITS'(timeout_ff);
         default:     prdata = '0;
      endcase
   end

   // handshake and frame sequencing
   logic                  busy_ff, busy_in;
   logic [FRAME_BITS-1:0] frame_ff, frame_in;
   logic [FRAME_BITS-1:0] last_ff, last_in;
   logic                  written_ff, written_in;
   logic                  reached_ff, reached_in;
   logic                  alive_ff, alive_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic                  out_free, emit, at_last, accept, tick_load, run;
   lane_ctl_type          lane_ctl;
   lane_stat_type [NUM_JOINTS-1:0] lane_stat;
   merge_type             merged;
   angle_type             goal_vec   [NUM_JOINTS];
   angle_type             sensed_vec [NUM_JOINTS];
   angle_type             frame_ang  [NUM_JOINTS];

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit      = busy_ff && out_free;
   assign at_last   = (frame_ff == last_ff);
   assign req_stall = busy_ff && !(emit && at_last);
   assign accept    = req_valid && !req_stall;
   assign tick_load = accept && (req_data.operation == OP_TICK);

   assign lane_ctl.accept  = accept;
   assign lane_ctl.op      = req_data.operation;
   assign lane_ctl.run     = run;
   assign lane_ctl.advance = emit;

   assign goal_vec[0]   = req_data.goal_a;
   assign goal_vec[1]   = req_data.goal_b;
   assign goal_vec[2]   = req_data.goal_c;
   assign sensed_vec[0] = req_data.sensed_a;
   assign sensed_vec[1] = req_data.sensed_b;
   assign sensed_vec[2] = req_data.sensed_c;

   for (genvar j = 0; j < NUM_JOINTS; j++) begin : g_lane
      mjsl_lane #(
         .NUM_FRAMES (NUM_FRAMES)
      ) u_lane (
         .clock       (clock),
         .reset       (reset),
         .ctl         (lane_ctl),
         .goal        (goal_vec[j]),
         .sensed      (sensed_vec[j]),
         .speed       (speed_ff[j]),
         .tol         (tol_ff),
         .stat        (lane_stat[j]),
         .frame_angle (frame_ang[j])
      );
   end

   mjsl_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .op          (req_data.operation),
      .now_ms      (req_data.now_ms),
      .stat        (lane_stat),
      .hold_enable (hold_ff),
      .timeout_ms  (timeout_ff),
      .run         (run),
      .result      (merged)
   );

   always_comb begin
      busy_in    = busy_ff;
      frame_in   = frame_ff;
      last_in    = last_ff;
      written_in = written_ff;
      reached_in = reached_ff;
      alive_in   = alive_ff;
      if (emit) begin
         if (at_last) begin
            busy_in = 1'b0;
         end else begin
            frame_in = frame_ff + 1'b1;
         end
      end
      if (tick_load) begin
         busy_in    = 1'b1;
         frame_in   = '0;
         last_in    = run ? FRAME_BITS'(NUM_FRAMES - 1) : '0;
         written_in = run;
         reached_in = merged.reached;
         alive_in   = merged.alive;
      end
   end

   always_comb begin
      rsp_valid_in = emit | (rsp_valid_ff & rsp_stall);
      rsp_data_in  = rsp_data_ff;
      if (emit) begin
         rsp_data_in.frame_index   = frame_ff;
         rsp_data_in.drive_a       = frame_ang[0];
         rsp_data_in.drive_b       = frame_ang[1];
         rsp_data_in.drive_c       = frame_ang[2];
         rsp_data_in.frame_written = written_ff;
         rsp_data_in.last_frame    = at_last;
         rsp_data_in.reached_event = at_last & reached_ff;
         rsp_data_in.alive         = alive_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_ff    <= frame_in;
      last_ff     <= last_in;
      written_ff  <= written_in;
      reached_ff  <= reached_in;
      alive_ff    <= alive_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `MJSL_ASSERT(a_frame_range, busy_ff |-> frame_ff <= last_ff, "frame counter past last frame")
   `MJSL_ASSERT(a_tick_loads, tick_load |=> busy_ff && frame_ff == '0, "tick did not start at frame 0")
   `MJSL_ASSERT(a_status_single, busy_ff && !written_ff |-> last_ff == '0, "status tick with several frames")
   `MJSL_ASSERT_ALWAYS(a_reset_idle, reset |=> !busy_ff && !rsp_valid_ff, "not idle after reset")

endmodule

`default_nettype wire

FILE: hw/rtl/mjsl_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module mjsl_lane
   import mjsl_pkg::*;
#(
   parameter int NUM_FRAMES = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  lane_ctl_type  ctl,
   input  angle_type     goal,
   input  angle_type     sensed,
   input  speed_type     speed,
   input  speed_type     tol,
   output lane_stat_type stat,
   output angle_type     frame_angle
);

   angle_type             target_ff, target_in;
   angle_type             command_ff, command_in;
   angle_type             base_ff, base_in;
   angle_type             goal_ff, goal_in;
   logic [ANGLE_BITS:0]   dist_ff, dist_in;
   logic                  neg_ff, neg_in;
   logic [OFF_BITS-1:0]   off_ff, off_in;

   logic [ANGLE_BITS:0]   diff, mag, sdiff, smag;
   logic [OFF_BITS-1:0]   span;
   logic [OFF_BITS:0]     cmd_x, base_x, reach, frame_reach;
   angle_type             final_angle;
   logic                  speed_zero;

   assign speed_zero = (speed == '0);

   // distance left to the target at the start of a tick
   assign diff = (ANGLE_BITS+1)'(target_ff) - (ANGLE_BITS+1)'(command_ff);
   assign mag  = diff[ANGLE_BITS] ? (~diff + 1'b1) : diff;
   assign span = OFF_BITS'(speed) * OFF_BITS'(NUM_FRAMES);

   assign stat.done = speed_zero || (OFF_BITS'(mag) <= span);

   assign cmd_x       = (OFF_BITS+1)'(command_ff);
   assign reach       = diff[ANGLE_BITS] ? (cmd_x - {1'b0, span}) : (cmd_x + {1'b0, span});
   assign final_angle = stat.done ? target_ff : angle_type'(reach[ANGLE_BITS-1:0]);

   assign sdiff        = (ANGLE_BITS+1)'(sensed) - (ANGLE_BITS+1)'(target_ff);
   assign smag         = sdiff[ANGLE_BITS] ? (~sdiff + 1'b1) : sdiff;
   assign stat.off_tol = smag > (ANGLE_BITS+1)'(tol);

   // per-frame value: off_ff holds (frame + 1) * speed
   assign base_x      = (OFF_BITS+1)'(base_ff);
   assign frame_reach = neg_ff ? (base_x - {1'b0, off_ff}) : (base_x + {1'b0, off_ff});
   assign frame_angle = (speed_zero || (OFF_BITS'(dist_ff) <= off_ff)) ?
                        goal_ff : angle_type'(frame_reach[ANGLE_BITS-1:0]);

   always_comb begin
      target_in  = target_ff;
      command_in = command_ff;
      base_in    = base_ff;
      goal_in    = goal_ff;
      dist_in    = dist_ff;
      neg_in     = neg_ff;
      off_in     = ctl.advance ? (off_ff + OFF_BITS'(speed)) : off_ff;
      if (ctl.accept) begin
         unique case (ctl.op)
            OP_SET: begin
               target_in = goal;
            end
            OP_SNAPSHOT: begin
               target_in  = sensed;
               command_in = sensed;
            end
            OP_FREEZE: begin
               target_in = command_ff;
            end
            OP_TICK: begin
               base_in = command_ff;
               off_in  = OFF_BITS'(speed);
               if (ctl.run) begin
                  goal_in    = target_ff;
                  dist_in    = mag;
                  neg_in     = diff[ANGLE_BITS];
                  command_in = final_angle;
               end else begin
                  goal_in = command_ff;
                  dist_in = '0;
                  neg_in  = 1'b0;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff  <= '0;
         command_ff <= '0;
      end else begin
         target_ff  <= target_in;
         command_ff <= command_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff <= base_in;
      goal_ff <= goal_in;
      dist_ff <= dist_in;
      neg_ff  <= neg_in;
      off_ff  <= off_in;
   end

endmodule

`default_nettype wire

FILE: hw/rtl/mjsl_merge.sv
`timescale 1ns / 1ps
`default_nettype none

module mjsl_merge
   import mjsl_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  op_type                         op,
   input  time_type                       now_ms,
   input  lane_stat_type [NUM_JOINTS-1:0] stat,
   input  logic                           hold_enable,
   input  time_type                       timeout_ms,
   output logic                           run,
   output merge_type                      result
);

   logic     pending_ff, pending_in;
   logic     arrived_ff, arrived_in;
   time_type arrival_ff, arrival_in;

   logic [NUM_JOINTS-1:0] done_vec, off_vec;
   logic     all_done, any_off, pend_tick, arrived_tick, late;
   time_type elapsed;

   always_comb begin
      for (int j = 0; j < NUM_JOINTS; j++) begin
         done_vec[j] = stat[j].done;
         off_vec[j]  = stat[j].off_tol;
      end
   end

   assign all_done = &done_vec;
   assign any_off  = |off_vec;

   assign run            = pending_ff | hold_enable;
   assign pend_tick      = run ? !all_done : pending_ff;
   assign result.reached = run && all_done && !arrived_ff;
   assign arrived_tick   = arrived_ff | result.reached;

   // elapsed counts from the stored arrival time; on the arrival tick itself late is held low
   assign elapsed = now_ms - arrival_ff;
   assign late    = !result.reached && (elapsed > timeout_ms);

   assign result.alive = pend_tick || !arrived_tick || (hold_enable && !late && any_off);

   always_comb begin
      pending_in = pending_ff;
      arrived_in = arrived_ff;
      arrival_in = arrival_ff;
      if (accept) begin
         unique case (op)
            OP_SET: begin
               pending_in = 1'b1;
               arrived_in = 1'b0;
            end
            OP_SNAPSHOT: begin
               pending_in = 1'b1;
            end
            OP_FREEZE: begin
               pending_in = 1'b0;
            end
            OP_TICK: begin
               pending_in = pend_tick;
               arrived_in = arrived_tick;
               if (result.reached) begin
                  arrival_in = now_ms;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b1;
         arrived_ff <= 1'b1;
         arrival_ff <= '0;
      end else begin
         pending_ff <= pending_in;
         arrived_ff <= arrived_in;
         arrival_ff <= arrival_in;
      end
   end

endmodule

`default_nettype wire
